// ----- rtl/amf_pkg.sv -----
package amf_pkg;

  // Field widths of the transactions and configuration registers.
  localparam int SAMPLE_BITS = 12;
  localparam int TIME_W      = 64;
  localparam int THR_W       = 7;
  localparam int BURST_W     = 8;
  localparam int QUIET_W     = 30;
  localparam int COUNT_W     = 8;
  localparam int CFG_W       = 30;
  localparam int CFG_IDX_W   = 2;

  // Both sides of the relative-change test are products of this width.
  localparam int PROD_W = SAMPLE_BITS + THR_W;

  localparam logic [THR_W-1:0]   PCT_SCALE   = THR_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(5);
  localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(3);
  localparam logic [QUIET_W-1:0] QUIET_RESET = QUIET_W'(10000000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET     = 2'd2;

  // Function codes of an input transaction.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CHECK  = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_W-1:0]      now_us;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic [COUNT_W-1:0]     fluct_count_out;
    logic                   burst_cleared;
    logic                   quiet_fire;
  } result_t;

endpackage

// ----- rtl/amf_ram.sv -----
module amf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/adc_moving_average_fluctuation_top.sv -----
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+-------------------------------------
// item     | item_valid   | item_stall   | item   (func, sample, now_us)
// result   | result_valid | result_stall | result (average, fluct_count_out,
//          |              |              |         burst_cleared, quiet_fire)
//
// A sample transaction passes S_SUM, S_DIV and S_PUT from acceptance to a
// loaded result register; in S_DIV the bit-serial divider forms sum /
// fill_count, one quotient bit per cycle. A check transaction passes
// S_CHK_ELAPSED, S_CHK_DECIDE and S_PUT. One transaction is in flight at a
// time; the next is accepted in the cycle after the result register loads.
// Reset is synchronous and active high; it clears the sum, counters and fill
// count and restores the register defaults. The ring needs no clearing pass:
// the fill count marks which ring slots have been written. A stalled result
// holds in the output register while the next transaction is already accepted
// and worked on; that one then waits in its final state until the output
// register frees up.
module adc_moving_average_fluctuation_top #(
  parameter int WINDOW = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  amf_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output amf_pkg::result_t             result,
  input  logic                         cfg_write,
  input  logic [amf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amf_pkg::CFG_W-1:0]    cfg_data
);

  // The sum of WINDOW readings fits in SUM_W bits, the fill count in FILL_W.
  localparam int POS_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = amf_pkg::SAMPLE_BITS + POS_W;
  localparam int CNT_W  = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_CHK_ELAPSED,
    S_CHK_DECIDE,
    S_PUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [amf_pkg::THR_W-1:0]   threshold_percent;
  logic [amf_pkg::BURST_W-1:0] burst_limit;
  logic [amf_pkg::QUIET_W-1:0] quiet_time_us;

  // Filter and detector state.
  logic [SUM_W-1:0]                running_sum;
  logic [POS_W-1:0]                write_pos;
  logic [FILL_W-1:0]               fill_count;
  logic [amf_pkg::SAMPLE_BITS-1:0] prev_sample;
  logic [amf_pkg::COUNT_W-1:0]     fluct_count;
  logic [amf_pkg::TIME_W-1:0]      last_fluct_time;
  logic [amf_pkg::SAMPLE_BITS-1:0] last_average;

  // Working registers of the transaction in flight.
  amf_pkg::item_t                  cur;
  amf_pkg::result_t                pending;
  logic [SUM_W-1:0]                dvd;
  logic [FILL_W-1:0]               rem;
  logic [CNT_W-1:0]                div_cnt;
  logic [amf_pkg::PROD_W-1:0]      change_scaled;
  logic [amf_pkg::PROD_W-1:0]      limit_scaled;
  logic [amf_pkg::TIME_W-1:0]      elapsed;

  // The ring of readings lives in a RAM with a registered read port. The read
  // address is the current write position, so the oldest reading is ready in
  // the cycle after acceptance.
  logic [amf_pkg::SAMPLE_BITS-1:0] ring_rdata;
  logic                            ring_we;

  assign ring_we = (state == S_SUM);

  amf_ram #(
    .WIDTH(amf_pkg::SAMPLE_BITS),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(write_pos),
    .wdata(cur.sample),
    .raddr(write_pos),
    .rdata(ring_rdata)
  );

  logic item_accept;
  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;

  // Sum update. Until the ring is full, the slot being replaced has never been
  // written and stands for a zero reading.
  logic                            ring_full;
  logic [amf_pkg::SAMPLE_BITS-1:0] oldest;
  logic [SUM_W-1:0]                running_sum_next;
  logic [POS_W-1:0]                write_pos_next;
  logic [amf_pkg::SAMPLE_BITS-1:0] diff;

  assign ring_full        = (fill_count == FILL_W'(WINDOW));
  assign oldest           = ring_full ? ring_rdata : '0;
  assign running_sum_next = running_sum - SUM_W'(oldest) + SUM_W'(cur.sample);
  assign write_pos_next   = (write_pos == POS_W'(WINDOW - 1)) ? '0 : write_pos + 1'b1;
  assign diff             = (cur.sample > prev_sample) ? cur.sample - prev_sample
                                                       : prev_sample - cur.sample;

  // One restoring division step: shift the next dividend bit into the
  // remainder and subtract the fill count where it fits.
  logic [FILL_W:0]   rem_shift;
  logic [FILL_W:0]   rem_sub;
  logic              quot_bit;
  logic [FILL_W-1:0] rem_next;
  logic [SUM_W-1:0]  dvd_next;

  assign rem_shift = {rem, dvd[SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, fill_count};
  assign quot_bit  = (rem_shift >= {1'b0, fill_count});
  assign rem_next  = quot_bit ? rem_sub[FILL_W-1:0] : rem_shift[FILL_W-1:0];
  assign dvd_next  = {dvd[SUM_W-2:0], quot_bit};

  // Fluctuation test, finished in the last division cycle. A zero previous
  // reading only restarts the quiet timer.
  logic                            prev_zero;
  logic                            is_fluct;
  logic [amf_pkg::COUNT_W-1:0]     fluct_inc;
  logic [amf_pkg::SAMPLE_BITS-1:0] average_next;

  assign prev_zero    = (prev_sample == '0);
  assign is_fluct     = !prev_zero && (change_scaled > limit_scaled);
  assign fluct_inc    = (fluct_count == amf_pkg::COUNT_MAX) ? fluct_count
                                                            : fluct_count + 1'b1;
  assign average_next = dvd_next[amf_pkg::SAMPLE_BITS-1:0];

  // Check decisions.
  logic cleared;
  logic fire;

  assign cleared = (fluct_count > burst_limit);
  assign fire    = (elapsed >= amf_pkg::TIME_W'(quiet_time_us));

  logic out_free;
  assign out_free = !result_valid || !result_stall;

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      result_valid      <= 1'b0;
      threshold_percent <= amf_pkg::THR_RESET;
      burst_limit       <= amf_pkg::BURST_RESET;
      quiet_time_us     <= amf_pkg::QUIET_RESET;
      running_sum       <= '0;
      write_pos         <= '0;
      fill_count        <= '0;
      prev_sample       <= '0;
      fluct_count       <= '0;
      last_fluct_time   <= '0;
      last_average      <= '0;
      div_cnt           <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          amf_pkg::CFG_THRESHOLD: threshold_percent <= cfg_data[amf_pkg::THR_W-1:0];
          amf_pkg::CFG_BURST:     burst_limit       <= cfg_data[amf_pkg::BURST_W-1:0];
          amf_pkg::CFG_QUIET:     quiet_time_us     <= cfg_data[amf_pkg::QUIET_W-1:0];
          default: ;
        endcase
      end

      // The output register empties when its transaction is taken, unless
      // a new result is loaded at the same edge.
      if (result_valid && !result_stall && state != S_PUT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_accept) begin
            state <= (item.func == amf_pkg::FUNC_CHECK) ? S_CHK_ELAPSED : S_SUM;
          end
        end
        S_SUM: begin
          running_sum <= running_sum_next;
          write_pos   <= write_pos_next;
          if (!ring_full) begin
            fill_count <= fill_count + 1'b1;
          end
          div_cnt <= CNT_W'(SUM_W - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            last_average <= average_next;
            prev_sample  <= cur.sample;
            if (is_fluct) begin
              fluct_count <= fluct_inc;
            end
            if (is_fluct || prev_zero) begin
              last_fluct_time <= cur.now_us;
            end
            state <= S_PUT;
          end
        end
        S_CHK_ELAPSED: begin
          state <= S_CHK_DECIDE;
        end
        S_CHK_DECIDE: begin
          if (cleared || fire) begin
            fluct_count <= '0;
          end
          if (fire) begin
            last_fluct_time <= cur.now_us;
          end
          state <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Payload and working registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      cur <= item;
    end
    if (state == S_SUM) begin
      dvd           <= running_sum_next;
      rem           <= '0;
      change_scaled <= amf_pkg::PROD_W'(diff) * amf_pkg::PROD_W'(amf_pkg::PCT_SCALE);
      limit_scaled  <= amf_pkg::PROD_W'(threshold_percent) * amf_pkg::PROD_W'(prev_sample);
    end
    if (state == S_DIV) begin
      dvd <= dvd_next;
      rem <= rem_next;
      if (div_cnt == '0) begin
        pending.average         <= average_next;
        pending.fluct_count_out <= is_fluct ? fluct_inc : fluct_count;
        pending.burst_cleared   <= 1'b0;
        pending.quiet_fire      <= 1'b0;
      end
    end
    if (state == S_CHK_ELAPSED) begin
      elapsed <= cur.now_us - last_fluct_time;
    end
    if (state == S_CHK_DECIDE) begin
      pending.average         <= last_average;
      pending.fluct_count_out <= (cleared || fire) ? '0 : fluct_count;
      pending.burst_cleared   <= cleared;
      pending.quiet_fire      <= fire;
    end
    if (state == S_PUT && out_free) begin
      result <= pending;
    end
  end

endmodule

// ----- rtl/amf_checker.sv -----
module amf_assertions (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input amf_pkg::result_t result
);

  // No result is shown and the input is open in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("result valid or input stalled right after reset");

  // An accepted transaction keeps the input stalled in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input open right after an accepted transaction");

  // A quiet fire always clears the fluctuation counter.
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.quiet_fire |-> result.fluct_count_out == '0)
    else $error("quiet fire with nonzero counter");

  // A burst clear always leaves the counter at zero.
  a_burst_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.burst_cleared |-> result.fluct_count_out == '0)
    else $error("burst clear with nonzero counter");

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind adc_moving_average_fluctuation_top amf_assertions u_amf_assertions (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

// ----- tb/amf_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the filter, keeps its
// own copy of the window, counters and settings, and compares every result
// transaction against the oldest prediction.
module amf_checker
  import amf_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   failures,
  output int                   pending
);

  logic [THR_W-1:0]       thr_pct;
  logic [BURST_W-1:0]     burst_max;
  logic [QUIET_W-1:0]     quiet_us;

  logic [SAMPLE_BITS-1:0] window_ring [WINDOW];
  int unsigned            window_sum;
  int unsigned            slot;
  int unsigned            filled;
  logic [SAMPLE_BITS-1:0] prev_reading;
  logic [COUNT_W-1:0]     change_count;
  logic [TIME_W-1:0]      last_change_us;
  logic [SAMPLE_BITS-1:0] held_average;

  result_t expected_results [$];
  result_t want;
  int      fail_count = 0;

  assign failures = fail_count;

  // Advances the filter by one input transaction and returns its result.
  function automatic result_t filter_response(input item_t it);
    result_t                r;
    logic [SAMPLE_BITS-1:0] delta;
    logic [63:0]            change_scaled;
    logic [63:0]            limit_scaled;
    r = '0;
    if (it.func == FUNC_SAMPLE) begin
      window_sum = window_sum - window_ring[slot] + it.sample;
      window_ring[slot] = it.sample;
      slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      if (filled < WINDOW) filled++;
      held_average = SAMPLE_BITS'(window_sum / filled);
      if (prev_reading != '0) begin
        delta = (it.sample > prev_reading) ? it.sample - prev_reading
                                           : prev_reading - it.sample;
        change_scaled = 64'(delta) * 64'd100;
        limit_scaled  = 64'(thr_pct) * 64'(prev_reading);
        if (change_scaled > limit_scaled) begin
          if (change_count != COUNT_MAX) change_count++;
          last_change_us = it.now_us;
        end
      end else begin
        last_change_us = it.now_us;
      end
      prev_reading = it.sample;
    end else begin
      if (change_count > burst_max) begin
        change_count = '0;
        r.burst_cleared = 1'b1;
      end
      // The subtraction wraps modulo 2^64 like a free-running timer.
      if (it.now_us - last_change_us >= 64'(quiet_us)) begin
        change_count = '0;
        r.quiet_fire = 1'b1;
        last_change_us = it.now_us;
      end
    end
    r.average = held_average;
    r.fluct_count_out = change_count;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      thr_pct = THR_RESET;
      burst_max = BURST_RESET;
      quiet_us = QUIET_RESET;
      for (int i = 0; i < WINDOW; i++) window_ring[i] = '0;
      window_sum = 0;
      slot = 0;
      filled = 0;
      prev_reading = '0;
      change_count = '0;
      last_change_us = '0;
      held_average = '0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_pct = cfg_data[THR_W-1:0];
          CFG_BURST:     burst_max = cfg_data[BURST_W-1:0];
          CFG_QUIET:     quiet_us = cfg_data[QUIET_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction avg=%0d count=%0d cleared=%0b fire=%0b",
                   $time, result.average, result.fluct_count_out,
                   result.burst_cleared, result.quiet_fire);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.average !== want.average ||
              result.fluct_count_out !== want.fluct_count_out ||
              result.burst_cleared !== want.burst_cleared ||
              result.quiet_fire !== want.quiet_fire) begin
            $display("%0t: mismatch expected avg=%0d count=%0d cleared=%0b fire=%0b",
                     $time, want.average, want.fluct_count_out,
                     want.burst_cleared, want.quiet_fire);
            $display("%0t:          actual   avg=%0d count=%0d cleared=%0b fire=%0b",
                     $time, result.average, result.fluct_count_out,
                     result.burst_cleared, result.quiet_fire);
            fail_count++;
          end
        end
      end
      if (item_valid && !item_stall) expected_results.push_back(filter_response(item));
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/tb_adc_moving_average_fluctuation_top.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the moving-average filter. The checker beside the
// block does all prediction and comparison; this module only drives the item
// channel, the result stall and the configuration port, and then reports.
module tb_adc_moving_average_fluctuation_top;
  import amf_pkg::*;

  localparam int WINDOW     = 16;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  // Cycles the receiver refuses results when a long hold-off is requested.
  // Far longer than one sample transaction, so the block fills and stalls.
  localparam int LONG_HOLD  = 400;
  // Settling time after the last result, well above a sample transaction.
  localparam int DRAIN_GAP  = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data = '0;

  int failure_count;
  int pending_results;

  // Traffic shaping. The sender idle percentage is read only by the main
  // process; the stall percentage and hold requests go to the receiver.
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned holds_wanted = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  // What the stimulus last sent, used to aim new readings near the
  // fluctuation threshold so both sides of the comparison get exercised.
  logic [TIME_W-1:0] cur_time = '0;
  int unsigned       last_sent = 0;
  int unsigned       cur_thr = 32'(THR_RESET);

  always #1 clk = ~clk;

  adc_moving_average_fluctuation_top #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  amf_checker #(
    .WINDOW(WINDOW)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failure_count),
    .pending     (pending_results)
  );

  // Receiver. A pending hold request starts a long stretch of stall that is
  // counted down here; otherwise the stall is drawn fresh every cycle.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_wanted) begin
      result_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // The run is cut off here if the block hangs or loses a transaction.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic item_t pack_item(input logic f, input logic [SAMPLE_BITS-1:0] s,
                                      input logic [TIME_W-1:0] t);
    item_t it;
    it.func = f;
    it.sample = s;
    it.now_us = t;
    return it;
  endfunction

  // Builds one random transaction. The clock mostly creeps forward by steps
  // scaled to the quiet time, and now and then jumps anywhere, which also
  // makes the elapsed time wrap. Readings are mostly placed right at, just
  // past or below the relative-change threshold of the previous reading.
  function automatic item_t gen_item(input int check_pct, input int unsigned span);
    item_t       it;
    int          v;
    int unsigned bound;
    int unsigned d;
    if ($urandom_range(0, 99) < 3) cur_time = {$urandom, $urandom};
    else cur_time = cur_time + $urandom_range(0, span);
    it.now_us = cur_time;
    it.sample = SAMPLE_BITS'($urandom);
    it.func = ($urandom_range(0, 99) < check_pct) ? FUNC_CHECK : FUNC_SAMPLE;
    if (it.func == FUNC_SAMPLE) begin
      case ($urandom_range(0, 9))
        0: it.sample = '0;
        1: it.sample = SAMPLE_BITS'(SAMPLE_MAX);
        2, 3: ;
        default: begin
          bound = last_sent * cur_thr / 100;
          case ($urandom_range(0, 2))
            0: d = bound;
            1: d = bound + 1;
            default: d = $urandom_range(0, bound + 2);
          endcase
          v = $urandom_range(0, 1) ? int'(last_sent) + int'(d) : int'(last_sent) - int'(d);
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          it.sample = SAMPLE_BITS'(v);
        end
      endcase
      last_sent = 32'(it.sample);
    end
    return it;
  endfunction

  // Offers one transaction, idling first at the current rate, and returns at
  // the falling edge after the block accepted it. Valid stays up between
  // back-to-back transactions.
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Sender pause: nothing is offered until every expected result is back,
  // and the block then sits idle for a while before any register write.
  task automatic wait_results_done();
    item_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Writes all three registers on consecutive cycles; the block is idle.
  task automatic write_settings(input logic [THR_W-1:0] thr, input logic [BURST_W-1:0] burst,
                                input logic [QUIET_W-1:0] quiet);
    cfg_write <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data <= CFG_W'(thr);
    @(negedge clk);
    cfg_index <= CFG_BURST;
    cfg_data <= CFG_W'(burst);
    @(negedge clk);
    cfg_index <= CFG_QUIET;
    cfg_data <= CFG_W'(quiet);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_thr = 32'(thr);
  endtask

  task automatic run_random_phase(input int n, input int idle_pct, input int stall_v,
                                  input int check_pct, input int unsigned span);
    send_idle_pct = idle_pct;
    stall_pct <= stall_v;
    repeat (n) send_item(gen_item(check_pct, span));
    wait_results_done();
  endtask

  initial begin
    logic [THR_W-1:0]   thr;
    logic [BURST_W-1:0] burst;
    logic [QUIET_W-1:0] quiet;
    logic [TIME_W-1:0]  t;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset settings: 5 percent, burst limit 3 and a
    // quiet time of ten seconds. A check before any sample reports a zero
    // average; the second check lands exactly on the quiet time and fires.
    t = 64'd10000000;
    send_item(pack_item(FUNC_CHECK, 12'd77, 64'd5));
    send_item(pack_item(FUNC_CHECK, 12'd0, t));
    // The first reading and any reading after a zero only record the time.
    send_item(pack_item(FUNC_SAMPLE, 12'd0, t + 1));
    send_item(pack_item(FUNC_SAMPLE, 12'd4095, t + 2));
    send_item(pack_item(FUNC_SAMPLE, 12'd0, t + 3));
    send_item(pack_item(FUNC_SAMPLE, 12'd100, t + 4));
    // 100 to 105 is a change of exactly 5 percent and must not count,
    // 105 to 110 stays under it, 110 to 116 is over it.
    send_item(pack_item(FUNC_SAMPLE, 12'd105, t + 5));
    send_item(pack_item(FUNC_SAMPLE, 12'd110, t + 6));
    send_item(pack_item(FUNC_SAMPLE, 12'd116, t + 7));
    send_item(pack_item(FUNC_SAMPLE, 12'd4095, t + 8));
    send_item(pack_item(FUNC_SAMPLE, 12'd1, t + 9));
    // Four fluctuations exceed the burst limit of three.
    send_item(pack_item(FUNC_CHECK, 12'd4095, t + 10));
    // A fluctuation just before the 64-bit timer wraps, then checks after
    // the wrap: a short elapsed time, then one past the quiet time.
    send_item(pack_item(FUNC_SAMPLE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFA));
    send_item(pack_item(FUNC_CHECK, 12'd0, 64'd20));
    send_item(pack_item(FUNC_CHECK, 12'd0, 64'd10000000));
    send_item(pack_item(FUNC_SAMPLE, 12'd2048, '1));
    // Enough further readings to fill the window and wrap the write slot.
    for (int i = 0; i < 7; i++) begin
      send_item(pack_item(FUNC_SAMPLE, 12'((i * 1337 + 5) % 4096), 64'd100 + i));
    end
    wait_results_done();

    // Zero threshold counts any change; a zero burst limit and a zero quiet
    // time make a single check both clear the counter and fire.
    write_settings('0, '0, '0);
    send_item(pack_item(FUNC_SAMPLE, 12'd7, 64'd1000));
    send_item(pack_item(FUNC_SAMPLE, 12'd8, 64'd1001));
    send_item(pack_item(FUNC_CHECK, 12'd0, 64'd1002));
    send_item(pack_item(FUNC_SAMPLE, 12'd8, 64'd1003));
    send_item(pack_item(FUNC_CHECK, 12'd0, 64'd1003));
    wait_results_done();

    // Threshold above 100 percent: 1000 to 2270 is exactly 127 percent.
    write_settings(7'd127, 8'd255, 30'd1);
    send_item(pack_item(FUNC_SAMPLE, 12'd1000, 64'd2000));
    send_item(pack_item(FUNC_SAMPLE, 12'd2270, 64'd2001));
    send_item(pack_item(FUNC_SAMPLE, 12'd2271, 64'd2002));
    send_item(pack_item(FUNC_CHECK, 12'd0, 64'd2003));
    wait_results_done();
    cur_time = 64'd2003;
    last_sent = 2271;

    // Random phases with random settings, one per traffic pattern. The one
    // with receiver stalls alone also gets a long hold-off while items keep coming.
    for (int p = 0; p < 4; p++) begin
      thr = THR_W'($urandom_range(1, 100));
      burst = BURST_W'($urandom_range(0, 6));
      quiet = QUIET_W'($urandom_range(1, 4000));
      write_settings(thr, burst, quiet);
      if (p == 2) holds_wanted <= holds_wanted + 1;
      run_random_phase(70, (p == 1) ? 47 : (p == 3) ? 24 : 0,
                       (p == 2) ? 47 : (p == 3) ? 24 : 0, 25, quiet / 3 + 1);
    end

    // Counter saturation: every change counts, checks never clear and the
    // longest quiet time never elapses, so alternating readings drive the
    // counter to its ceiling and keep it there.
    write_settings('0, 8'd255, '1);
    stall_pct <= 24;
    holds_wanted <= holds_wanted + 1;
    for (int i = 0; i < 130; i++) begin
      cur_time = cur_time + 1;
      send_item(pack_item(FUNC_SAMPLE, 12'd1, cur_time));
      send_item(pack_item(FUNC_SAMPLE, 12'd2, cur_time));
    end
    last_sent = 2;
    run_random_phase(100, 0, 24, 2, 1000);

    // Extremes of the other side: highest threshold, burst limit zero and a
    // one-microsecond quiet time.
    write_settings(7'd127, '0, 30'd1);
    run_random_phase(60, 24, 24, 40, 2);

    // Full threshold with a quiet time of 1000000000 microseconds and large time steps.
    write_settings(7'd100, BURST_W'($urandom_range(0, 255)), 30'd1000000000);
    run_random_phase(60, 47, 47, 30, 400000000);

    if (failure_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
